FILE: sv/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants for the bounded positional list
// Command and result payload structs, operation codes and field widths.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int CNT_W = 5;
    localparam int VAL_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;
    localparam logic [VAL_W-1:0] VAL_NONE  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_PURGE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [CNT_W-1:0]   position;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] read_value;
        logic [CNT_W-1:0]   entry_count;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
    } result_t;

endpackage

FILE: sv/bpl_ram.sv
// ----------------------------------------------------------------------------
// bpl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered list with positional insert/remove/get
// Entries live in one RAM; a sequencer shifts, reads and purges through it.
//
//   channel | signals                         | transfer
//   --------+---------------------------------+-----------------------------
//   command | start, busy, cmd                | start high and busy low
//   result  | done, result                    | done high, one cycle, no stall
//   config  | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready high
//
// Get reads the entry, then the summary; rejects go straight to the summary.
// Insert and remove first shift the entries behind the position one place
// over. Each shift is one RAM read then one write.
// Purge reads each entry and compares it against the kept ones.
// Reset clears the count and sets capacity to 10; RAM contents are not cleared.
// Results cannot be stalled; busy stays high until the result strobe.
// ----------------------------------------------------------------------------
module bounded_positional_list #(
    parameter int DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  bpl_pkg::cmd_t           cmd,
    output logic                    done,
    output bpl_pkg::result_t        result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [bpl_pkg::CNT_W-1:0] cfg_data
);

    import bpl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_MV_RD, S_MV_WR, S_PUT, S_GET_W,
        S_P_RDI, S_P_CAP, S_P_RDJ, S_P_CMP,
        S_HEAD, S_TAIL, S_FIN
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] p);
        logic [8:0] w;
        w = 9'(p);
        return w[AW-1:0];
    endfunction

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] cap_reg;
    mode_t            op_reg, op_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [VAL_W-1:0] cur_reg, cur_next;
    logic             status_reg, status_next;
    logic [VAL_W-1:0] readv_reg, readv_next;
    logic [VAL_W-1:0] head_reg, head_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;
    logic [CNT_W-1:0] limit;
    logic             ins_reject;
    logic [CNT_W:0]   ptr_p2;

    bpl_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // effective capacity and insert checks
    assign limit = (9'(cap_reg) < DEPTH_W) ? cap_reg : DEPTH_W[CNT_W-1:0];
    assign ins_reject = (used_reg >= limit) || (cmd.position > used_reg)
                        || (cmd.position > cap_reg);
    assign ptr_p2 = {1'b0, ptr_reg} + 6'd2;

    // sequencer next-state logic
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        kept_next   = kept_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        readv_next  = readv_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.mode;
                    pos_next    = cmd.position;
                    val_next    = cmd.value;
                    status_next = 1'b0;
                    readv_next  = '0;
                    case (cmd.mode)
                        MODE_INSERT:
                        begin
                            if (ins_reject)
                            begin
                                status_next = 1'b1;
                                state_next  = S_HEAD;
                            end
                            else if (cmd.position == used_reg)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ptr_next   = used_reg;
                                state_next = S_MV_RD;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (cmd.position >= used_reg)
                            begin
                                status_next = 1'b1;
                                state_next  = S_HEAD;
                            end
                            else if (6'(cmd.position) + 6'd1 >= 6'(used_reg))
                            begin
                                used_next  = used_reg - 5'd1;
                                state_next = S_HEAD;
                            end
                            else
                            begin
                                ptr_next   = cmd.position;
                                state_next = S_MV_RD;
                            end
                        end
                        MODE_GET:
                        begin
                            if (cmd.position < used_reg)
                            begin
                                ram_raddr  = to_addr(cmd.position);
                                state_next = S_GET_W;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                readv_next  = VAL_NONE;
                                state_next  = S_HEAD;
                            end
                        end
                        default:
                        begin
                            i_next     = '0;
                            kept_next  = '0;
                            state_next = S_P_RDI;
                        end
                    endcase
                end
            end

            // shift: read the source neighbor
            S_MV_RD:
            begin
                if (op_reg == MODE_INSERT)
                begin
                    ram_raddr = to_addr(ptr_reg - 5'd1);
                end
                else
                begin
                    ram_raddr = to_addr(ptr_reg + 5'd1);
                end
                state_next = S_MV_WR;
            end

            // shift: write it one place over
            S_MV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(ptr_reg);
                ram_wdata = ram_rdata;
                if (op_reg == MODE_INSERT)
                begin
                    ptr_next = ptr_reg - 5'd1;
                    if (ptr_reg - 5'd1 == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_MV_RD;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 5'd1;
                    if (ptr_p2 >= 6'(used_reg))
                    begin
                        used_next  = used_reg - 5'd1;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_MV_RD;
                    end
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = to_addr(pos_reg);
                ram_wdata  = val_reg;
                used_next  = used_reg + 5'd1;
                state_next = S_HEAD;
            end

            S_GET_W:
            begin
                readv_next = ram_rdata;
                state_next = S_HEAD;
            end

            // purge: fetch entry i
            S_P_RDI:
            begin
                if (i_reg >= used_reg)
                begin
                    used_next  = kept_reg;
                    state_next = S_HEAD;
                end
                else
                begin
                    ram_raddr  = to_addr(i_reg);
                    state_next = S_P_CAP;
                end
            end

            S_P_CAP:
            begin
                cur_next   = ram_rdata;
                j_next     = '0;
                state_next = S_P_RDJ;
            end

            // purge: scan kept entries, or keep this one
            S_P_RDJ:
            begin
                if (j_reg >= kept_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = to_addr(kept_reg);
                    ram_wdata  = cur_reg;
                    kept_next  = kept_reg + 5'd1;
                    i_next     = i_reg + 5'd1;
                    state_next = S_P_RDI;
                end
                else
                begin
                    ram_raddr  = to_addr(j_reg);
                    state_next = S_P_CMP;
                end
            end

            S_P_CMP:
            begin
                if (ram_rdata == cur_reg)
                begin
                    i_next     = i_reg + 5'd1;
                    state_next = S_P_RDI;
                end
                else
                begin
                    j_next     = j_reg + 5'd1;
                    state_next = S_P_RDJ;
                end
            end

            // summary: head then tail
            S_HEAD:
            begin
                if (used_reg == '0)
                begin
                    result_next.status      = status_reg;
                    result_next.read_value  = readv_reg;
                    result_next.entry_count = used_reg;
                    result_next.head_value  = VAL_NONE;
                    result_next.tail_value  = VAL_NONE;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                head_next  = ram_rdata;
                ram_raddr  = to_addr(used_reg - 5'd1);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                result_next.status      = status_reg;
                result_next.read_value  = readv_reg;
                result_next.entry_count = used_reg;
                result_next.head_value  = head_reg;
                result_next.tail_value  = ram_rdata;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        kept_reg   <= kept_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        readv_reg  <= readv_next;
        head_reg   <= head_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        9'(used_reg) <= DEPTH_W)
        else $error("entry count above depth");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.entry_count == '0) |-> (result.head_value == -32'sd1))
        else $error("empty list reported a head value");
`endif

endmodule

FILE: tb/sv/bounded_positional_list_test.sv
// ----------------------------------------------------------------------------
// bounded_positional_list_test: self-checking bench for the positional list
// Drives insert/remove/get/purge commands through start/busy, models the list
// in a local shadow copy, and compares every done strobe field by field.
// Capacity is rewritten between phases only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_positional_list_test;

    import bpl_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_CYC   = 1000000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             done;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // shadow list state
    logic signed [31:0] shadow_list [DEPTH];
    int unsigned        shadow_used;
    int unsigned        shadow_cap;

    result_t pending_results [$];
    int      fail_count;
    int      item_count;
    int      result_count;
    int      cycle_count;
    int      burst_left;

    bounded_positional_list #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // compute expected result and advance the shadow list
    function automatic result_t list_apply(cmd_t c);
        result_t            r;
        int unsigned        lim;
        int unsigned        pos;
        int unsigned        kept;
        bit                 seen;
        logic signed [31:0] tmp [DEPTH];
        begin
            r = '0;
            pos = c.position;
            lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
            case (c.mode)
                MODE_INSERT:
                begin
                    if (shadow_used >= lim || pos > shadow_used || pos > shadow_cap)
                        r.status = 1'b1;
                    else
                    begin
                        for (int i = shadow_used; i > pos; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[pos] = c.value;
                        shadow_used++;
                    end
                end
                MODE_REMOVE:
                begin
                    if (pos >= shadow_used)
                        r.status = 1'b1;
                    else
                    begin
                        for (int i = pos; i + 1 < shadow_used; i++)
                            shadow_list[i] = shadow_list[i+1];
                        shadow_used--;
                    end
                end
                MODE_GET:
                begin
                    if (pos < shadow_used)
                        r.read_value = shadow_list[pos];
                    else
                    begin
                        r.read_value = VAL_NONE;
                        r.status = 1'b1;
                    end
                end
                default:
                begin
                    kept = 0;
                    for (int i = 0; i < shadow_used; i++)
                    begin
                        seen = 1'b0;
                        for (int j = 0; j < kept; j++)
                            if (tmp[j] == shadow_list[i])
                                seen = 1'b1;
                        if (!seen)
                        begin
                            tmp[kept] = shadow_list[i];
                            kept++;
                        end
                    end
                    for (int i = 0; i < kept; i++)
                        shadow_list[i] = tmp[i];
                    shadow_used = kept;
                end
            endcase
            r.entry_count = shadow_used[CNT_W-1:0];
            r.head_value  = (shadow_used > 0) ? shadow_list[0] : VAL_NONE;
            r.tail_value  = (shadow_used > 0) ? shadow_list[shadow_used-1] : VAL_NONE;
            return r;
        end
    endfunction

    // one command transfer, with bursty gaps in front
    task automatic send_cmd(mode_t m, int unsigned pos, logic signed [31:0] v);
        cmd_t c;
        cmd_t junk;
        begin
            // gap in front of each transfer
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
            else
            begin
                burst_left--;
                @(posedge clk);
            end
            c.mode = m;
            c.position = pos[CNT_W-1:0];
            c.value = v;
            start <= 1'b1;
            cmd   <= c;
            do
                @(posedge clk);
            while (busy);
            pending_results.push_back(list_apply(c));
            item_count++;
            junk.mode     = mode_t'($urandom_range(0, 3));
            junk.position = CNT_W'($urandom);
            junk.value    = $urandom;
            start <= 1'b0;
            cmd   <= junk;
        end
    endtask

    // wait until nothing is outstanding and busy is low, then idle before returning
    task automatic drain_results();
        begin
            while (pending_results.size() != 0 || busy)
                @(posedge clk);
            repeat (4 + 4 * DEPTH * DEPTH) @(posedge clk);
        end
    endtask

    task automatic write_capacity(int unsigned cap);
        begin
            drain_results();
            cfg_valid <= 1'b1;
            cfg_data  <= cap[CNT_W-1:0];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            shadow_cap = cap;
        end
    endtask

    // values drawn mostly from a small pool so purge finds duplicates
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 1);
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    task automatic test_directed();
        begin
            send_cmd(MODE_GET, 0, 0);
            send_cmd(MODE_REMOVE, 0, 0);
            send_cmd(MODE_PURGE, 0, 0);
            send_cmd(MODE_INSERT, 1, 5);
            send_cmd(MODE_INSERT, 0, 32'h7FFF_FFFF);
            send_cmd(MODE_INSERT, 1, 32'h8000_0000);
            send_cmd(MODE_INSERT, 1, 32'hFFFF_FFFF);
            send_cmd(MODE_INSERT, 0, 32'h7FFF_FFFF);
            send_cmd(MODE_GET, 2, 0);
            send_cmd(MODE_GET, 4, 0);
            send_cmd(MODE_GET, 31, 0);
            send_cmd(MODE_REMOVE, 4, 0);
            send_cmd(MODE_PURGE, 0, 0);
            send_cmd(MODE_REMOVE, 1, 0);
            for (int i = 0; i < 8; i++)
                send_cmd(MODE_INSERT, 0, i);
            send_cmd(MODE_INSERT, 0, 99);
            send_cmd(MODE_REMOVE, 9, 0);
        end
    endtask

    // capacity edge cases: zero, one, below count, above depth
    task automatic test_capacity_edges();
        begin
            write_capacity(3);
            send_cmd(MODE_INSERT, 0, 1);
            send_cmd(MODE_PURGE, 0, 0);
            write_capacity(0);
            send_cmd(MODE_INSERT, 0, 1);
            while (shadow_used > 0)
                send_cmd(MODE_REMOVE, 0, 0);
            send_cmd(MODE_INSERT, 0, 1);
            write_capacity(1);
            send_cmd(MODE_INSERT, 1, 2);
            send_cmd(MODE_INSERT, 0, 2);
            send_cmd(MODE_INSERT, 0, 3);
            write_capacity(31);
            for (int i = 0; i < 17; i++)
                send_cmd(MODE_INSERT, $urandom_range(0, shadow_used), i % 3);
            send_cmd(MODE_INSERT, 16, 7);
            send_cmd(MODE_GET, 15, 0);
            send_cmd(MODE_GET, 16, 0);
            send_cmd(MODE_PURGE, 0, 0);
        end
    endtask

    task automatic test_random(int n);
        int unsigned pos;
        int unsigned sel;
        begin
            for (int k = 0; k < n; k++)
            begin
                sel = $urandom_range(0, 99);
                pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, shadow_used);
                if (sel < 45)
                    send_cmd(MODE_INSERT, pos, pick_value());
                else if (sel < 70)
                    send_cmd(MODE_REMOVE, pos, $urandom);
                else if (sel < 93)
                    send_cmd(MODE_GET, pos, $urandom);
                else
                    send_cmd(MODE_PURGE, $urandom_range(0, 31), $urandom);
            end
        end
    endtask

    task automatic test_random_phases();
        begin
            write_capacity(16);
            test_random(300);
            // hold off until everything has come back
            while (pending_results.size() != 0)
                @(posedge clk);
            test_random(50);
            write_capacity($urandom_range(1, 15));
            test_random(250);
            write_capacity(10);
            test_random(250);
            write_capacity($urandom_range(16, 31));
            test_random(100);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h", $time, result);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.status !== result.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             result.status);
                    fail_count++;
                end
                if (exp_r.read_value !== result.read_value)
                begin
                    $display("%0t: read_value exp %0d got %0d", $time,
                             exp_r.read_value, result.read_value);
                    fail_count++;
                end
                if (exp_r.entry_count !== result.entry_count)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_r.entry_count, result.entry_count);
                    fail_count++;
                end
                if (exp_r.head_value !== result.head_value)
                begin
                    $display("%0t: head_value exp %0d got %0d", $time,
                             exp_r.head_value, result.head_value);
                    fail_count++;
                end
                if (exp_r.tail_value !== result.tail_value)
                begin
                    $display("%0t: tail_value exp %0d got %0d", $time,
                             exp_r.tail_value, result.tail_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYC)
        begin
            $display("bounded_positional_list_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        fail_count  = 0;
        item_count  = 0;
        result_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        shadow_used = 0;
        shadow_cap  = CAP_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity_edges();
        test_random_phases();
        drain_results();
        $display("Covered %0d commands and %0d results across capacities 0..31,",
                 item_count, result_count);
        $display("including full, out-of-range and duplicate-purge cases.");
        if (fail_count == 0)
            $display("bounded_positional_list_test OK");
        else
            $display("bounded_positional_list_test NOT OK");
        $finish;
    end

endmodule
